>>> design/mbrc_pkg.sv
// Modbus RTU response checker: shared types, constants and the CRC-16 step.
// Used by every other design file but mbrc_ifs.sv; depends on nothing.
package mbrc_pkg;

   localparam int MaxFrameBytesDef = 256;
   localparam int QueueDepth       = 4;
   localparam int QueuePtrW        = $clog2(QueueDepth);

   localparam logic [15:0] CrcPoly       = 16'hA001;
   localparam logic [15:0] CrcInit       = 16'hFFFF;
   localparam logic [7:0]  ExcBit        = 8'h80;
   localparam logic [7:0]  FuncReadHold  = 8'h03;
   localparam logic [7:0]  FuncReadInput = 8'h04;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_SHORT = 3'd1,
      ST_CRC   = 3'd2,
      ST_EXC   = 3'd3,
      ST_LEN   = 3'd4,
      ST_EMPTY = 3'd5
   } status_type;

   typedef enum logic {
      KIND_PAYLOAD = 1'b0,
      KIND_STATUS  = 1'b1
   } kind_type;

   // Classified result, queued between front and back.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       too_short;
      logic       crc_bad;
      logic       exc;
      logic       len_bad;
      logic [7:0] count;
   } item_type;

   // One byte through the reflected CRC-16, eight shift steps unrolled.
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ CrcPoly;
         else      c = c >> 1;
      end
      return c;
   endfunction

endpackage

>>> design/mbrc_ifs.sv
// Valid/ready channel interfaces for the request bytes and the response items.
// Depends on nothing.
interface mbrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_end;
   modport source (output valid, output rx_byte, output frame_end, input ready);
   modport sink (input valid, input rx_byte, input frame_end, output ready);
endinterface

interface mbrc_rsp_if;
   logic       valid;
   logic       ready;
   logic       item_kind;
   logic [7:0] payload_byte;
   logic [2:0] frame_status;
   logic [7:0] payload_count;
   logic       is_last;
   modport source (output valid, output item_kind, output payload_byte, output frame_status,
                   output payload_count, output is_last, input ready);
   modport sink (input valid, input item_kind, input payload_byte, input frame_status,
                 input payload_count, input is_last, output ready);
endinterface

>>> design/mbrc_front.sv
// Front end: accepts frame bytes, runs the CRC and position tracking, and
// classifies each byte into a queued item. Depends on mbrc_pkg, mbrc_ifs.
module mbrc_front #(
   parameter int MAX_FRAME_BYTES = mbrc_pkg::MaxFrameBytesDef
) (
   input  logic              clock,
   input  logic              reset,
   mbrc_req_if.sink          req_bus,
   input  logic              queue_full,
   output logic              push_valid,
   output mbrc_pkg::item_type push_item
);
   localparam int PosW = $clog2(MAX_FRAME_BYTES + 2);
   localparam int LenW = PosW + 1;
   localparam int CmpW = (LenW > 9) ? LenW : 9;
   localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES + 1);

   logic [PosW-1:0] pos_ff, pos_in;
   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      held_ff [2];
   logic [7:0]      held_in [2];
   logic [7:0]      fc_ff, fc_in;
   logic [7:0]      cnt_ff, cnt_in;

   logic            accept;
   logic [7:0]      b;
   logic [7:0]      fc_now, cnt_now;
   logic [15:0]     crc_next;
   logic [CmpW-1:0] len_c, cnt_c, pay_end;
   logic            is_read;

   assign req_bus.ready = !queue_full;
   assign accept = req_bus.valid && req_bus.ready;
   assign b      = req_bus.rx_byte;

   always_comb begin
      fc_now   = (pos_ff == PosW'(1)) ? b : fc_ff;
      cnt_now  = (pos_ff == PosW'(2)) ? b : cnt_ff;
      crc_next = (pos_ff >= PosW'(2)) ? mbrc_pkg::crc_feed(crc_ff, held_ff[0]) : crc_ff;
      len_c    = CmpW'(pos_ff) + CmpW'(1);
      cnt_c    = CmpW'(cnt_now) + CmpW'(5);
      pay_end  = CmpW'(cnt_ff) + CmpW'(3);
      is_read  = (fc_ff == mbrc_pkg::FuncReadHold) || (fc_ff == mbrc_pkg::FuncReadInput);

      push_item.count     = cnt_now;
      push_item.too_short = (pos_ff < PosW'(3));
      // received CRC: low byte first, so the byte before last is the low half
      push_item.crc_bad   = (crc_next != {b, held_ff[1]});
      push_item.exc       = (fc_now & mbrc_pkg::ExcBit) != 8'h00;
      push_item.len_bad   = (len_c > CmpW'(MAX_FRAME_BYTES)) || (cnt_c != len_c);
      push_item.data      = b;
      if (req_bus.frame_end) begin
         push_item.kind = mbrc_pkg::KIND_STATUS;
         push_valid     = accept;
      end else begin
         push_item.kind = mbrc_pkg::KIND_PAYLOAD;
         push_valid     = accept && (pos_ff >= PosW'(3)) && (CmpW'(pos_ff) < pay_end) && is_read;
      end

      pos_in     = pos_ff;
      crc_in     = crc_ff;
      held_in[0] = held_ff[0];
      held_in[1] = held_ff[1];
      fc_in      = fc_ff;
      cnt_in     = cnt_ff;
      if (accept) begin
         if (req_bus.frame_end) begin
            pos_in     = '0;
            crc_in     = mbrc_pkg::CrcInit;
            held_in[0] = '0;
            held_in[1] = '0;
            fc_in      = '0;
            cnt_in     = '0;
         end else begin
            if (pos_ff < PosMax) pos_in = pos_ff + PosW'(1);
            crc_in     = crc_next;
            held_in[0] = held_ff[1];
            held_in[1] = b;
            fc_in      = fc_now;
            cnt_in     = cnt_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         crc_ff     <= mbrc_pkg::CrcInit;
         held_ff[0] <= '0;
         held_ff[1] <= '0;
         fc_ff      <= '0;
         cnt_ff     <= '0;
      end else begin
         pos_ff     <= pos_in;
         crc_ff     <= crc_in;
         held_ff[0] <= held_in[0];
         held_ff[1] <= held_in[1];
         fc_ff      <= fc_in;
         cnt_ff     <= cnt_in;
      end
   end

endmodule

>>> design/mbrc_queue.sv
// Short FIFO of classified items between front and back end.
// Depends on mbrc_pkg.
module mbrc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mbrc_pkg::item_type push_item,
   output logic               full,
   input  logic               pop,
   output logic               empty,
   output mbrc_pkg::item_type head_item
);
   localparam int PtrW = mbrc_pkg::QueuePtrW;

   mbrc_pkg::item_type store_ff [mbrc_pkg::QueueDepth];
   logic [PtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PtrW:0]   fill_ff, fill_in;
   logic            do_push, do_pop;

   assign full      = (fill_ff == (PtrW+1)'(mbrc_pkg::QueueDepth));
   assign empty     = (fill_ff == '0);
   assign head_item = store_ff[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_in   = do_push ? wr_ff + PtrW'(1) : wr_ff;
      rd_in   = do_pop ? rd_ff + PtrW'(1) : rd_ff;
      fill_in = fill_ff;
      if (do_push && !do_pop) fill_in = fill_ff + (PtrW+1)'(1);
      if (do_pop && !do_push) fill_in = fill_ff - (PtrW+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) store_ff[wr_ff] <= push_item;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

endmodule

>>> design/mbrc_back.sv
// Back end: resolves the frame status from the queued check flags and holds
// the result in an output register. Depends on mbrc_pkg, mbrc_ifs.
module mbrc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  mbrc_pkg::item_type head_item,
   output logic               pop,
   mbrc_rsp_if.source         rsp_bus
);
   logic                 valid_ff, valid_in;
   logic                 kind_ff, kind_in;
   logic [7:0]           data_ff, data_in;
   mbrc_pkg::status_type status_ff, status_in;
   logic [7:0]           count_ff, count_in;
   mbrc_pkg::status_type status_now;

   assign pop = !empty && (!valid_ff || rsp_bus.ready);

   always_comb begin
      priority if (head_item.too_short) status_now = mbrc_pkg::ST_SHORT;
      else if (head_item.crc_bad)       status_now = mbrc_pkg::ST_CRC;
      else if (head_item.exc)           status_now = mbrc_pkg::ST_EXC;
      else if (head_item.len_bad)       status_now = mbrc_pkg::ST_LEN;
      else if (head_item.count == 8'h00) status_now = mbrc_pkg::ST_EMPTY;
      else                              status_now = mbrc_pkg::ST_OK;

      valid_in  = valid_ff && !rsp_bus.ready;
      kind_in   = kind_ff;
      data_in   = data_ff;
      status_in = status_ff;
      count_in  = count_ff;
      if (pop) begin
         valid_in = 1'b1;
         if (head_item.kind == mbrc_pkg::KIND_STATUS) begin
            kind_in   = 1'b1;
            data_in   = '0;
            status_in = status_now;
            count_in  = head_item.count;
         end else begin
            kind_in   = 1'b0;
            data_in   = head_item.data;
            status_in = mbrc_pkg::ST_OK;
            count_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      data_ff   <= data_in;
      status_ff <= status_in;
      count_ff  <= count_in;
   end

   assign rsp_bus.valid         = valid_ff;
   assign rsp_bus.item_kind     = kind_ff;
   assign rsp_bus.payload_byte  = data_ff;
   assign rsp_bus.frame_status  = status_ff;
   assign rsp_bus.payload_count = count_ff;
   assign rsp_bus.is_last       = kind_ff;

endmodule

>>> design/modbus_rtu_response_checker.sv
// Checks a Modbus RTU response fed one byte per transaction, the last byte
// flagged by frame_end. One byte is accepted every cycle while the four-entry
// result queue has room; a byte's result passes through the queue and the
// output register before it reaches rsp_bus. For function 3 or 4, payload
// bytes go out as tentative items; the frame's last byte always yields one
// status item (is_last high) and the payload is good only if that status is
// ok. The CRC (reflected 0xA001, init 0xFFFF) runs one byte per cycle while
// bytes are accepted; the received CRC is taken low byte first. Frames longer
// than MAX_FRAME_BYTES report length mismatch unless an earlier check fails.
module modbus_rtu_response_checker #(
   parameter int MAX_FRAME_BYTES = mbrc_pkg::MaxFrameBytesDef
) (
   input logic        clock,
   input logic        reset,
   mbrc_req_if.sink   req_bus,
   mbrc_rsp_if.source rsp_bus
);
   logic               push_valid, queue_full, queue_empty, pop;
   mbrc_pkg::item_type push_item, head_item;

   mbrc_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   mbrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .empty     (queue_empty),
      .head_item (head_item)
   );

   mbrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .head_item (head_item),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );

endmodule
